// ----- hw/rtl/plsq_pkg.sv -----
// Package for the priority LED pattern sequencer.
// Holds the command codes, the input item and result structs, and fixed widths.
// No dependencies; every other file of the block but the checker imports it.
package plsq_pkg;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 2;
  localparam int BITS_W  = 32;
  localparam int LEN_W   = 6;
  localparam int ID_W    = 8;
  localparam int REP_W   = 16;

  localparam logic [SLOT_W-1:0] MANUAL_SLOT_RST = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_STEADY = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [SLOT_W-1:0]        slot;
    logic [BITS_W-1:0]        bits;
    logic [LEN_W-1:0]         len;
    logic [ID_W-1:0]          id;
    logic signed [REP_W-1:0]  rep;
    logic                     steady;
  } item_t;

  typedef struct packed {
    logic led_on;
    logic slot_running;
  } res_t;

endpackage

// ----- hw/rtl/plsq_in_reg.sv -----
// Input register stage of the priority LED pattern sequencer.
// Captures one command item per transfer and holds it until the core takes it.
// Depends on plsq_pkg.
module plsq_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  plsq_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output plsq_pkg::item_t item
);
  import plsq_pkg::*;

  logic  vld_r;
  item_t item_r;

  // The stage can refill in the same cycle that its item moves on.
  assign in_ready   = !vld_r || take;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/plsq_slot_bank.sv -----
// Slot bank of the priority LED pattern sequencer: per-slot pattern state,
// the set/clear/tick update and the LED level that follows it.
// Depends on plsq_pkg.
module plsq_slot_bank #(
  parameter int SLOTS        = 4,
  parameter int PATTERN_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  plsq_pkg::item_t             item,
  input  logic [plsq_pkg::SLOT_W-1:0] manual_slot,
  output plsq_pkg::res_t              res
);
  import plsq_pkg::*;

  localparam int PW = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
  localparam int LW = $clog2(PATTERN_BITS + 1);
  localparam int CW = LW + 1;
  localparam logic [LEN_W:0] PB_MAX = (LEN_W + 1)'(PATTERN_BITS);

  logic [PATTERN_BITS-1:0] pat_r   [SLOTS];
  logic [PATTERN_BITS-1:0] pat_nxt [SLOTS];
  logic [ID_W-1:0]         id_r    [SLOTS];
  logic [ID_W-1:0]         id_nxt  [SLOTS];
  logic [LW-1:0]           len_r   [SLOTS];
  logic [LW-1:0]           len_nxt [SLOTS];
  logic [PW-1:0]           pos_r   [SLOTS];
  logic [PW-1:0]           pos_nxt [SLOTS];
  logic signed [REP_W-1:0] rep_r   [SLOTS];
  logic signed [REP_W-1:0] rep_nxt [SLOTS];
  logic                    act_r   [SLOTS];
  logic                    act_nxt [SLOTS];
  logic                    top_oh  [SLOTS];
  logic                    steady_r;
  logic                    steady_nxt;

  logic [LW-1:0]           len_sat;
  logic [PATTERN_BITS-1:0] pat_in;
  logic [2*BITS_W-1:0]     bits_ext;
  logic                    any_act;

  // Lengths above the pattern width saturate; pattern bits above it are dropped.
  assign len_sat  = ({1'b0, item.len} > PB_MAX) ? LW'(PB_MAX) : LW'(item.len);
  assign bits_ext = {{BITS_W{1'b0}}, item.bits};
  assign pat_in   = bits_ext[PATTERN_BITS-1:0];

  // Highest active slot before the update; a tick advances only that one.
  always_comb begin
    logic higher;
    higher  = 1'b0;
    any_act = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      top_oh[i] = act_r[i] && !higher;
      higher    = higher || act_r[i];
    end
    any_act = higher;
  end

  assign steady_nxt = (go && item.cmd == CMD_STEADY) ? item.steady : steady_r;

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    logic          hit;
    logic          is_manual;
    logic          wrap;
    logic [CW-1:0] pos_inc;

    assign hit       = (int'(item.slot) == g);
    assign is_manual = (item.slot == manual_slot);
    assign pos_inc   = CW'(pos_r[g]) + CW'(1);
    assign wrap      = (pos_inc >= {1'b0, len_r[g]});

    always_comb begin
      pat_nxt[g] = pat_r[g];
      id_nxt[g]  = id_r[g];
      len_nxt[g] = len_r[g];
      pos_nxt[g] = pos_r[g];
      rep_nxt[g] = rep_r[g];
      act_nxt[g] = act_r[g];
      if (go) begin
        unique case (item.cmd)
          CMD_SET: begin
            if (hit) begin
              if (item.rep == '0) begin
                act_nxt[g] = 1'b0;
              end else if (!is_manual && act_r[g] &&
                           (id_r[g] == item.id || rep_r[g] >= 0)) begin
                // Same pattern, or a finite run still in progress: keep it.
                act_nxt[g] = act_r[g];
              end else if (item.len == '0) begin
                act_nxt[g] = 1'b0;
              end else begin
                pat_nxt[g] = pat_in;
                id_nxt[g]  = item.id;
                len_nxt[g] = len_sat;
                pos_nxt[g] = '0;
                rep_nxt[g] = item.rep;
                act_nxt[g] = 1'b1;
              end
            end
          end
          CMD_CLEAR: begin
            if (hit) begin
              act_nxt[g] = 1'b0;
            end
          end
          CMD_STEADY: begin
            act_nxt[g] = act_r[g];
          end
          CMD_TICK: begin
            if (top_oh[g]) begin
              if (wrap) begin
                pos_nxt[g] = '0;
                if (rep_r[g] > 0) begin
                  rep_nxt[g] = rep_r[g] - 16'sd1;
                  if (rep_r[g] == 16'sd1) begin
                    act_nxt[g] = 1'b0;
                  end
                end
              end else begin
                pos_nxt[g] = pos_inc[PW-1:0];
              end
            end
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        act_r[g] <= 1'b0;
      end else begin
        act_r[g] <= act_nxt[g];
      end
    end

    always_ff @(posedge clk) begin
      pat_r[g] <= pat_nxt[g];
      id_r[g]  <= id_nxt[g];
      len_r[g] <= len_nxt[g];
      pos_r[g] <= pos_nxt[g];
      rep_r[g] <= rep_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_r <= 1'b0;
    end else begin
      steady_r <= steady_nxt;
    end
  end

  // The LED follows the highest slot that is active after the update.
  always_comb begin
    logic found;
    found      = 1'b0;
    res.led_on = steady_nxt;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (act_nxt[i] && !found) begin
        res.led_on = pat_nxt[i][pos_nxt[i]];
        found      = 1'b1;
      end
    end
    res.slot_running = (item.cmd == CMD_TICK) && any_act;
  end

endmodule

// ----- hw/rtl/priority_led_pattern_sequencer.sv -----
// Top level of the priority LED pattern sequencer.
// Instantiates plsq_in_reg and plsq_slot_bank and holds the result register.
// Depends on plsq_pkg.
//
// Usage: every command arrives as one transfer on the in_ channel (valid and
// ready) and produces exactly one result transfer on the out_ channel: the
// LED level after the command and, for a tick, whether a slot was running.
// Commands set a pattern slot, clear a slot, set the steady level, or tick the
// highest active slot one step forward.
// The item passes an input register, then, in the cycle in which the core takes
// it, the slot bank updates its state and loads the result register, which
// drives out_valid; a result thus passes both registers before it is offered.
// One item per cycle is sustained when out_ready is high. The cost per item
// is one pass through the slot priority encoder and the per-slot update logic.
// cfg_we writes the manual slot register from cfg_wdata, with no
// handshake; the manual slot skips the same-pattern and running checks on set.
// Reset (rst_n low, synchronous) deactivates every slot, clears the steady
// level, empties both registers and sets the manual slot to the highest index.
// When the receiver stalls, the result holds in the output register, one
// further item waits in the input register, and in_ready then drops.
module priority_led_pattern_sequencer #(
  parameter int SLOTS        = 4,
  parameter int PATTERN_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plsq_pkg::CMD_W-1:0]        in_cmd,
  input  logic [plsq_pkg::SLOT_W-1:0]       in_slot,
  input  logic [plsq_pkg::BITS_W-1:0]       in_pattern_bits,
  input  logic [plsq_pkg::LEN_W-1:0]        in_pattern_length,
  input  logic [plsq_pkg::ID_W-1:0]         in_pattern_id,
  input  logic signed [plsq_pkg::REP_W-1:0] in_repeat_count,
  input  logic                              in_steady_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_led_on,
  output logic                              out_slot_running,
  input  logic                              cfg_we,
  input  logic [plsq_pkg::SLOT_W-1:0]       cfg_wdata
);
  import plsq_pkg::*;

  item_t             in_item;
  item_t             item;
  logic              item_valid;
  logic              take;
  res_t              res;
  logic [SLOT_W-1:0] manual_slot_r;
  logic              out_valid_r;
  res_t              out_res_r;

  assign in_item.cmd    = cmd_t'(in_cmd);
  assign in_item.slot   = in_slot;
  assign in_item.bits   = in_pattern_bits;
  assign in_item.len    = in_pattern_length;
  assign in_item.id     = in_pattern_id;
  assign in_item.rep    = in_repeat_count;
  assign in_item.steady = in_steady_value;

  // The held item is processed whenever the result register is free or is
  // being emptied in this same cycle.
  assign take = item_valid && (!out_valid_r || out_ready);

  plsq_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  plsq_slot_bank #(
    .SLOTS        (SLOTS),
    .PATTERN_BITS (PATTERN_BITS)
  ) u_slot_bank (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (take),
    .item        (item),
    .manual_slot (manual_slot_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_slot_r <= MANUAL_SLOT_RST;
    end else if (cfg_we) begin
      manual_slot_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_on       = out_res_r.led_on;
  assign out_slot_running = out_res_r.slot_running;

endmodule

// ----- hw/rtl/plsq_checker.sv -----
// Port-level checker for the priority LED pattern sequencer.
// Watches only the top level's ports; bound to the top level below.
// Depends on nothing but the top level's port list.
module plsq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_led_on,
  input logic out_slot_running
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_led_on) && $stable(out_slot_running))
    else $error("result changed while stalled");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Input backpressure only arises from a stalled receiver.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Without backpressure an accepted transfer always yields a result once it has
  // passed the input register and the core has loaded the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid ##1 out_ready |=> out_valid)
    else $error("accepted transfer produced no result");

endmodule

bind priority_led_pattern_sequencer plsq_checker u_plsq_checker (.*);

// ----- dv/priority_led_pattern_sequencer_tb.sv -----
// Self-checking testbench for the priority LED pattern sequencer.
// Depends on plsq_pkg and the priority_led_pattern_sequencer RTL; nothing else.
// The testbench predicts each result, checks it, and sweeps the manual slot setting.
`timescale 1ns / 100ps

module priority_led_pattern_sequencer_tb;
  import plsq_pkg::*;

  localparam logic signed [REP_W-1:0] REP_FOREVER = -16'sd1;
  // Random commands per manual slot setting, four settings in all.
  localparam int PHASE_CMDS = 406;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic [SLOT_W-1:0]        in_slot = '0;
  logic [BITS_W-1:0]        in_pattern_bits = '0;
  logic [LEN_W-1:0]         in_pattern_length = '0;
  logic [ID_W-1:0]          in_pattern_id = '0;
  logic signed [REP_W-1:0]  in_repeat_count = '0;
  logic                     in_steady_value = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_led_on;
  logic                     out_slot_running;
  logic                     cfg_we = 1'b0;
  logic [SLOT_W-1:0]        cfg_wdata = '0;

  priority_led_pattern_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_slot           (in_slot),
    .in_pattern_bits   (in_pattern_bits),
    .in_pattern_length (in_pattern_length),
    .in_pattern_id     (in_pattern_id),
    .in_repeat_count   (in_repeat_count),
    .in_steady_value   (in_steady_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_led_on        (out_led_on),
    .out_slot_running  (out_slot_running),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The run is bounded by simulation time: 1 ms, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the sequencer state. Pattern fields of a slot are only read
  // while that slot is active, so they never need a reset value.
  // ---------------------------------------------------------------------------
  logic [BITS_W-1:0]        pat_bits   [4];
  logic [ID_W-1:0]          pat_id     [4];
  logic [LEN_W-1:0]         pat_len    [4];
  logic [4:0]               pat_pos    [4];
  logic signed [REP_W-1:0]  pat_rep    [4];
  logic                     pat_active [4];
  logic                     steady_lvl;
  logic [SLOT_W-1:0]        manual_sel;

  item_t cmd_q[$];
  res_t  led_results_q[$];

  int mismatches   = 0;
  int accepted     = 0;
  int checked      = 0;
  int n_sets       = 0;
  int n_ticks_run  = 0;
  int n_ticks_idle = 0;
  int n_settings   = 1;

  // Highest active slot, or -1 when every slot is idle.
  function automatic int top_pattern();
    for (int i = 3; i >= 0; i--) begin
      if (pat_active[i]) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow state and returns the LED result it
  // should produce.
  function automatic res_t predict_led(input item_t it);
    res_t        r;
    int          t;
    logic        blocked;
    logic [LEN_W-1:0] eff_len;
    r.slot_running = 1'b0;
    case (it.cmd)
      CMD_SET: begin
        // Zero repeats clears the slot before any other check, manual or not.
        if (it.rep == 0) begin
          pat_active[it.slot] = 1'b0;
        end else begin
          // Outside the manual slot, an active slot holding the same id or a
          // finite run still in progress keeps what it has.
          blocked = (it.slot != manual_sel) && pat_active[it.slot] &&
                    ((pat_id[it.slot] == it.id) || (pat_rep[it.slot] >= 0));
          if (!blocked) begin
            if (it.len == 0) begin
              pat_active[it.slot] = 1'b0;
            end else begin
              eff_len = (it.len > BITS_W) ? LEN_W'(BITS_W) : it.len;
              pat_bits[it.slot]   = it.bits;
              pat_id[it.slot]     = it.id;
              pat_len[it.slot]    = eff_len;
              pat_pos[it.slot]    = '0;
              pat_rep[it.slot]    = it.rep;
              pat_active[it.slot] = 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        pat_active[it.slot] = 1'b0;
      end
      CMD_STEADY: begin
        steady_lvl = it.steady;
      end
      default: begin
        t = top_pattern();
        if (t >= 0) begin
          r.slot_running = 1'b1;
          if (int'(pat_pos[t]) + 1 >= int'(pat_len[t])) begin
            // Wrap: count down a finite run and retire the slot at zero.
            pat_pos[t] = '0;
            if (pat_rep[t] > 0) pat_rep[t] = pat_rep[t] - 16'sd1;
            if (pat_rep[t] == 0) pat_active[t] = 1'b0;
          end else begin
            pat_pos[t] = pat_pos[t] + 5'd1;
          end
        end
      end
    endcase
    t = top_pattern();
    r.led_on = (t < 0) ? steady_lvl : pat_bits[t][pat_pos[t]];
    return r;
  endfunction

  function automatic item_t make_cmd(input cmd_t c, input logic [SLOT_W-1:0] s,
                                     input logic [BITS_W-1:0] b, input logic [LEN_W-1:0] l,
                                     input logic [ID_W-1:0] id,
                                     input logic signed [REP_W-1:0] rep, input logic sv);
    item_t it;
    it.cmd    = c;
    it.slot   = s;
    it.bits   = b;
    it.len    = l;
    it.id     = id;
    it.rep    = rep;
    it.steady = sv;
    return it;
  endfunction

  // Random command. Most sets use short patterns, few repeats and a small pool
  // of ids so that runs finish, priorities change hands and the same-id and
  // still-running checks fire often; the rest hit the full field ranges.
  function automatic item_t random_cmd();
    item_t       it;
    int unsigned pick;
    it.bits   = $urandom();
    it.slot   = SLOT_W'($urandom_range(3));
    it.steady = 1'($urandom_range(1));
    it.id     = ($urandom_range(3) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(3));
    pick = $urandom_range(19);
    if (pick == 0)      it.len = '0;
    else if (pick == 1) it.len = LEN_W'($urandom_range(33, 63));
    else if (pick == 2) it.len = LEN_W'(BITS_W);
    else                it.len = LEN_W'($urandom_range(1, 8));
    pick = $urandom_range(19);
    if (pick == 0)      it.rep = '0;
    else if (pick <= 2) it.rep = REP_W'($urandom());
    else if (pick <= 6) it.rep = REP_FOREVER;
    else if (pick == 7) it.rep = REP_W'($urandom()) | 16'sh8000;
    else                it.rep = REP_W'($urandom_range(1, 3));
    pick = $urandom_range(99);
    if (pick < 48)      it.cmd = CMD_TICK;
    else if (pick < 78) it.cmd = CMD_SET;
    else if (pick < 89) it.cmd = CMD_CLEAR;
    else                it.cmd = CMD_STEADY;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pulls pending commands and presents them in bursts of random length
  // separated by random gaps. A zero gap lets bursts run back to back, which
  // gives long stretches of one transfer per cycle while in_ready stays high.
  // ---------------------------------------------------------------------------
  int    burst_left = 1;
  int    gap_left   = 0;
  item_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0 || cmd_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        nxt = cmd_q.pop_front();
        in_valid          <= 1'b1;
        in_cmd            <= nxt.cmd;
        in_slot           <= nxt.slot;
        in_pattern_bits   <= nxt.bits;
        in_pattern_length <= nxt.len;
        in_pattern_id     <= nxt.id;
        in_repeat_count   <= nxt.rep;
        in_steady_value   <= nxt.steady;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver back-pressure: a mode is held for a random stretch of cycles.
  // Modes are always ready, coin flip, mostly stalled, and strict alternation.
  int unsigned stall_mode = 0;
  int          stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(1) == 0);
      2:       out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker. Every input transfer is run through the predictor at
  // the edge where it is accepted; every output transfer is compared with the
  // oldest prediction still waiting. Configuration writes update the shadow
  // manual slot at the same edge the block takes them.
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  item_t taken;
  res_t  want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) pat_active[i] = 1'b0;
      steady_lvl = 1'b0;
      manual_sel = MANUAL_SLOT_RST;
    end else begin
      if (cfg_we) manual_sel = cfg_wdata;
      if (out_valid && out_ready) begin
        if (led_results_q.size() == 0) begin
          log_mismatch($sformatf("result with nothing expected: led_on %0b slot_running %0b",
                                 out_led_on, out_slot_running));
        end else begin
          want = led_results_q.pop_front();
          checked++;
          if (out_led_on !== want.led_on)
            log_mismatch($sformatf("result %0d led_on expected %0b actual %0b",
                                   checked, want.led_on, out_led_on));
          if (out_slot_running !== want.slot_running)
            log_mismatch($sformatf("result %0d slot_running expected %0b actual %0b",
                                   checked, want.slot_running, out_slot_running));
        end
      end
      if (in_valid && in_ready) begin
        taken.cmd    = cmd_t'(in_cmd);
        taken.slot   = in_slot;
        taken.bits   = in_pattern_bits;
        taken.len    = in_pattern_length;
        taken.id     = in_pattern_id;
        taken.rep    = in_repeat_count;
        taken.steady = in_steady_value;
        want = predict_led(taken);
        led_results_q.push_back(want);
        accepted++;
        if (taken.cmd == CMD_SET) n_sets++;
        if (taken.cmd == CMD_TICK) begin
          if (want.slot_running) n_ticks_run++;
          else n_ticks_idle++;
        end
      end
    end
  end

  // Waits until every pending command has been transferred and every result
  // has come back, then lets the block settle so that it is truly quiet.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid || led_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_manual(input logic [SLOT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening under the reset manual slot, then one random
  // phase per manual slot setting, with the register only written while idle.
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] settings [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Ticks with nothing active show the steady level, both values of it.
    cmd_q.push_back(make_cmd(CMD_TICK,   2'd0, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_STEADY, 2'd0, '0, '0, '0, '0, 1'b1));
    cmd_q.push_back(make_cmd(CMD_TICK,   2'd2, '1, '1, '1, '1, 1'b0));
    // Overlong pattern that runs forever, then the same id is refused.
    cmd_q.push_back(make_cmd(CMD_SET, 2'd1, 32'hAAAA_AAAA, 6'd63, 8'd0, REP_FOREVER, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, 2'd1, 32'hFFFF_FFFF, 6'd4, 8'd0, 16'sd5, 1'b0));
    // A new id replaces a forever pattern; a finite run then refuses a new id.
    cmd_q.push_back(make_cmd(CMD_SET, 2'd1, 32'h0000_0005, 6'd2, 8'd255, 16'sd2, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, 2'd1, 32'h0000_0000, 6'd8, 8'd7, 16'sd3, 1'b0));
    repeat (4) cmd_q.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, '0, 1'b0));
    // Zero repeats and zero length both clear.
    cmd_q.push_back(make_cmd(CMD_SET, 2'd2, 32'hFFFF_FFFF, 6'd5, 8'd3, 16'sd0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, 2'd2, 32'hFFFF_FFFF, 6'd0, 8'd3, 16'sd1, 1'b0));
    // Full-length pattern with the largest repeat count in a low slot.
    cmd_q.push_back(make_cmd(CMD_SET, 2'd0, 32'h8000_0001, 6'd32, 8'd128, 16'sh7FFF, 1'b0));
    // The manual slot restarts even with the same id and a finite run going.
    cmd_q.push_back(make_cmd(CMD_SET, 2'd3, 32'h0000_0001, 6'd1, 8'd9, 16'sd1, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, 2'd3, 32'h0000_0000, 6'd3, 8'd9, 16'sh8000, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_CLEAR, 2'd3, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_STEADY, 2'd0, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_CLEAR, 2'd0, '0, '0, '0, '0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, '0, 1'b0));
    // A single-step pattern played once retires on its first tick.
    cmd_q.push_back(make_cmd(CMD_SET, 2'd0, 32'hFFFF_FFFF, 6'd1, 8'd1, 16'sd1, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, '0, 1'b0));
    wait_idle();

    foreach (settings[k]) begin
      write_manual(settings[k]);
      repeat (PHASE_CMDS) cmd_q.push_back(random_cmd());
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (led_results_q.size() != 0) begin
      mismatches += led_results_q.size();
      $display("%0d expected results never arrived", led_results_q.size());
    end
    $display("Ran %0d commands (%0d sets, %0d ticks with a slot running, %0d idle ticks)",
             accepted, n_sets, n_ticks_run, n_ticks_idle);
    $display("over %0d manual slot settings; %0d results checked, %0d mismatches.",
             n_settings, checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
